>>> hw/rtl/bbr_pkg.sv
// shared types and constants for the 3x3 box blur block
package bbr_pkg;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd800;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd600;

    // stream payload
    localparam int IN_W   = 32;
    localparam int PIX_W  = 24;
    localparam int PIX_LO = 8;
    localparam int CHAN_W = 8;

    // channel sums and divide by nine through a reciprocal
    localparam int SUM_W        = 12;
    localparam int RECIP9_W     = 12;
    localparam int RECIP9_SHIFT = 15;
    localparam logic [RECIP9_W-1:0] RECIP9 = 12'd3641;
    localparam int PROD_W = SUM_W + RECIP9_W;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // sequencer that rebuilds dimensions and output position after a register write
    typedef enum logic [3:0] {
        SEQ_IDLE  = 4'b0001,
        SEQ_CLAMP = 4'b0010,
        SEQ_MUL   = 4'b0100,
        SEQ_DIV   = 4'b1000
    } seq_state_t;

endpackage

>>> hw/rtl/box_blur_3x3_rgb_unit.sv
// 3x3 box blur over an rgba8888 raster stream, line stores in one block memory
//
//  channel   dir  signals                          carries
//  s         in   s_tvalid s_tready s_tdata s_tuser  pixel (tdata), cmd (tuser)
//  m         out  m_tvalid m_tready m_tdata m_tlast  blurred pixel, last of frame
//  cfg       in   cfg_we cfg_index cfg_data          frame_width, frame_height
//
// one request per clock while s_tready is high; results go s1 -> s2 -> output register.
// the line store is a single 48-bit memory, read on accept, written back as s1 advances;
// back-to-back requests on the same column (one-pixel lines) take the forwarded value.
// after reset the frame is 800 x 600 (clamped to the maximum sizes).
// each register write holds s_tready low while the sizes are clamped, the total is rebuilt
// and the output position is re-divided by the new width.
// while a result waits on m_tready, requests are taken until s2 and s1 both hold results.
module box_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bbr_pkg::IN_W-1:0]           s_tdata,   // [31:0] in_pixel
    input  logic                               s_tuser,   // [0] cmd

    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bbr_pkg::IN_W-1:0]           m_tdata,   // [31:0] out_color
    output logic                               m_tlast,   // out_last

    input  logic                               cfg_we,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbr_pkg::CFG_W-1:0]          cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);            // column / memory address
    localparam int WW   = $clog2(MAX_WIDTH + 1);        // clamped width
    localparam int HW   = $clog2(MAX_HEIGHT + 1);       // clamped height
    localparam int XW   = WW + 1;                       // column compares
    localparam int RW   = HW + 2;                       // input row, saturating
    localparam int TW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DCW  = $clog2(TW + 1);
    localparam int CLWW = (bbr_pkg::CFG_W > WW) ? bbr_pkg::CFG_W : WW;
    localparam int CLHW = (bbr_pkg::CFG_W > HW) ? bbr_pkg::CFG_W : HW;
    localparam int MEM_W = 2 * bbr_pkg::PIX_W;
    localparam int PW   = bbr_pkg::PIX_W;
    localparam int SW   = bbr_pkg::SUM_W;
    localparam int CH   = bbr_pkg::CHAN_W;

    localparam int RST_W = (int'(bbr_pkg::RESET_WIDTH) > MAX_WIDTH) ?
                           MAX_WIDTH : int'(bbr_pkg::RESET_WIDTH);
    localparam int RST_H = (int'(bbr_pkg::RESET_HEIGHT) > MAX_HEIGHT) ?
                           MAX_HEIGHT : int'(bbr_pkg::RESET_HEIGHT);
    localparam int RST_T = RST_W * RST_H;

    // ---------------------------------------------------------------- configuration
    logic [bbr_pkg::CFG_W-1:0] cfg_width_reg;
    logic [bbr_pkg::CFG_W-1:0] cfg_height_reg;
    logic [WW-1:0]             w_reg;
    logic [HW-1:0]             h_reg;
    logic [TW-1:0]             total_reg;
    bbr_pkg::seq_state_t       seq_reg;
    logic [WW-1:0]             div_rem_reg;
    logic [TW-1:0]             div_q_reg;
    logic [DCW-1:0]            div_cnt_reg;

    logic [WW-1:0]             w_clamp;
    logic [HW-1:0]             h_clamp;
    logic [WW:0]               rem_sh;
    logic                      rem_ge;
    logic [WW-1:0]             div_rem_next;
    logic [TW-1:0]             div_q_next;
    logic                      busy;

    // ---------------------------------------------------------------- front end state
    logic [CW-1:0]             in_column_reg;
    logic [RW-1:0]             in_row_reg;
    logic [TW-1:0]             out_count_reg;
    logic [CW-1:0]             ox_reg;
    logic [TW-1:0]             oy_reg;

    // ---------------------------------------------------------------- pipeline
    logic                      s1_valid_reg;
    logic [CW-1:0]             s1_addr_reg;
    logic [PW-1:0]             s1_v_reg;
    logic                      s1_has_reg;
    logic                      s1_last_reg;
    logic [2:0]                s1_col_en_reg;
    logic [2:0]                s1_row_en_reg;
    logic                      s1_fwd_reg;
    logic [MEM_W-1:0]          fwd_reg;
    logic [MEM_W-1:0]          line_rd_reg;
    logic [MEM_W-1:0]          line_mem [MAX_WIDTH];
    logic [PW-1:0]             win_reg [3][3];

    logic                      s2_valid_reg;
    logic                      s2_last_reg;
    logic [SW-1:0]             s2_sum_reg [3];

    logic                      out_valid_reg;
    logic                      out_last_reg;
    logic [bbr_pkg::IN_W-1:0]  out_color_reg;

    // ---------------------------------------------------------------- clamp and divide step
    always_comb
    begin
        if (cfg_width_reg == '0)
            w_clamp = WW'(1);
        else if (CLWW'(cfg_width_reg) > CLWW'(MAX_WIDTH))
            w_clamp = WW'(MAX_WIDTH);
        else
            w_clamp = WW'(cfg_width_reg);

        if (cfg_height_reg == '0)
            h_clamp = HW'(1);
        else if (CLHW'(cfg_height_reg) > CLHW'(MAX_HEIGHT))
            h_clamp = HW'(MAX_HEIGHT);
        else
            h_clamp = HW'(cfg_height_reg);

        rem_sh       = {div_rem_reg, div_q_reg[TW-1]};
        rem_ge       = rem_sh >= (WW+1)'(w_reg);
        div_rem_next = rem_ge ? WW'(rem_sh - (WW+1)'(w_reg)) : WW'(rem_sh);
        div_q_next   = {div_q_reg[TW-2:0], rem_ge};
    end

    assign busy = (seq_reg != bbr_pkg::SEQ_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= bbr_pkg::RESET_WIDTH;
            cfg_height_reg <= bbr_pkg::RESET_HEIGHT;
            w_reg          <= WW'(RST_W);
            h_reg          <= HW'(RST_H);
            total_reg      <= TW'(RST_T);
            seq_reg        <= bbr_pkg::SEQ_IDLE;
            div_rem_reg    <= '0;
            div_q_reg      <= '0;
            div_cnt_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbr_pkg::REG_FRAME_WIDTH:  cfg_width_reg  <= cfg_data;
                bbr_pkg::REG_FRAME_HEIGHT: cfg_height_reg <= cfg_data;
                default: ;
            endcase
            seq_reg <= bbr_pkg::SEQ_CLAMP;
        end
        else
        begin
            case (seq_reg)
                bbr_pkg::SEQ_IDLE: ;
                bbr_pkg::SEQ_CLAMP:
                begin
                    w_reg   <= w_clamp;
                    h_reg   <= h_clamp;
                    seq_reg <= bbr_pkg::SEQ_MUL;
                end
                bbr_pkg::SEQ_MUL:
                begin
                    total_reg   <= TW'(TW'(w_reg) * TW'(h_reg));
                    div_rem_reg <= '0;
                    div_q_reg   <= out_count_reg;
                    div_cnt_reg <= DCW'(TW);
                    seq_reg     <= bbr_pkg::SEQ_DIV;
                end
                bbr_pkg::SEQ_DIV:
                begin
                    div_rem_reg <= div_rem_next;
                    div_q_reg   <= div_q_next;
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                    if (div_cnt_reg == DCW'(1))
                        seq_reg <= bbr_pkg::SEQ_IDLE;
                end
                default: seq_reg <= bbr_pkg::SEQ_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake chain
    logic ready1, ready2, ready3;
    logic s1_adv, s2_mv;
    logic accept, do_item, draining;

    assign ready3 = !out_valid_reg || m_tready;
    assign ready2 = !s2_valid_reg || ready3;
    assign s2_mv  = s2_valid_reg && ready3;
    assign s1_adv = s1_valid_reg && (!s1_has_reg || ready2);
    assign ready1 = !s1_valid_reg || s1_adv;

    assign s_tready = ready1 && !busy && !cfg_we;
    assign accept   = s_tvalid && s_tready;
    assign draining = in_row_reg >= RW'(h_reg);
    // a flush before the frame is complete is taken and dropped
    assign do_item  = accept && (!s_tuser || draining);

    // ---------------------------------------------------------------- front end
    logic              pos_ok, has_res, is_last, col_wrap;
    logic [CW-1:0]     in_column_next;
    logic [RW-1:0]     in_row_next;
    logic [PW-1:0]     v_in;
    logic [2:0]        col_en, row_en;

    always_comb
    begin
        v_in = draining ? '0 : s_tdata[bbr_pkg::PIX_LO +: PW];

        // result once the input is at least one line plus one pixel ahead
        pos_ok = (in_row_reg >= RW'(2))
              || ((in_row_reg == RW'(1)) && (in_column_reg != '0))
              || ((in_row_reg == '0) && (XW'(in_column_reg) > XW'(w_reg)));
        has_res = do_item && pos_ok;
        is_last = has_res && (((TW+1)'(out_count_reg) + (TW+1)'(1)) >= (TW+1)'(total_reg));

        col_wrap       = (XW'(in_column_reg) + XW'(1)) >= XW'(w_reg);
        in_column_next = col_wrap ? '0 : in_column_reg + CW'(1);
        in_row_next    = (col_wrap && (in_row_reg != '1)) ? in_row_reg + RW'(1) : in_row_reg;

        col_en[0] = ox_reg != '0;
        col_en[1] = 1'b1;
        col_en[2] = (XW'(ox_reg) + XW'(1)) < XW'(w_reg);
        row_en[0] = (oy_reg != '0) && (oy_reg <= TW'(h_reg));
        row_en[1] = oy_reg < TW'(h_reg);
        row_en[2] = ((TW+1)'(oy_reg) + (TW+1)'(1)) < (TW+1)'(h_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg <= '0;
            in_row_reg    <= '0;
            out_count_reg <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
        end
        else if ((seq_reg == bbr_pkg::SEQ_DIV) && (div_cnt_reg == DCW'(1)) && !cfg_we)
        begin
            ox_reg <= CW'(div_rem_next);
            oy_reg <= div_q_next;
        end
        else if (do_item)
        begin
            if (is_last)
            begin
                in_column_reg <= '0;
                in_row_reg    <= '0;
                out_count_reg <= '0;
                ox_reg        <= '0;
                oy_reg        <= '0;
            end
            else
            begin
                in_column_reg <= in_column_next;
                in_row_reg    <= in_row_next;
                if (has_res)
                begin
                    out_count_reg <= out_count_reg + TW'(1);
                    if ((XW'(ox_reg) + XW'(1)) >= XW'(w_reg))
                    begin
                        ox_reg <= '0;
                        oy_reg <= oy_reg + TW'(1);
                    end
                    else
                        ox_reg <= ox_reg + CW'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------- line store
    logic [MEM_W-1:0] line_eff;
    logic [PW-1:0]    above_eff, mid_eff;
    logic [MEM_W-1:0] line_wr;

    assign line_eff  = s1_fwd_reg ? fwd_reg : line_rd_reg;
    assign above_eff = line_eff[MEM_W-1:PW];
    assign mid_eff   = line_eff[PW-1:0];
    assign line_wr   = {mid_eff, s1_v_reg};

    always_ff @(posedge clk)
    begin
        if (do_item)
            line_rd_reg <= line_mem[in_column_reg];
        if (s1_adv)
            line_mem[s1_addr_reg] <= line_wr;
    end

    always_ff @(posedge clk)
    begin
        if (do_item)
        begin
            s1_addr_reg   <= in_column_reg;
            s1_v_reg      <= v_in;
            s1_col_en_reg <= col_en;
            s1_row_en_reg <= row_en;
            s1_last_reg   <= is_last;
            fwd_reg       <= line_wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_has_reg   <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else if (do_item)
        begin
            s1_valid_reg <= 1'b1;
            s1_has_reg   <= has_res;
            // previous request writes this column at the same edge as this read
            s1_fwd_reg   <= s1_adv && (s1_addr_reg == in_column_reg);
        end
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // ---------------------------------------------------------------- window and sums
    logic [PW-1:0] win_next [3][3];
    logic [SW-1:0] col_sum  [3][3];
    logic [SW-1:0] sum_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[0][r] = win_reg[1][r];
            win_next[1][r] = win_reg[2][r];
        end
        win_next[2][0] = above_eff;
        win_next[2][1] = mid_eff;
        win_next[2][2] = s1_v_reg;

        // per colour channel k (0 blue, 1 green, 2 red) and column c
        for (int k = 0; k < 3; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                col_sum[k][c] = '0;
                for (int r = 0; r < 3; r++)
                    if (s1_col_en_reg[c] && s1_row_en_reg[r])
                        col_sum[k][c] = col_sum[k][c] + SW'(win_next[c][r][k*CH +: CH]);
            end
            sum_next[k] = col_sum[k][0] + col_sum[k][1] + col_sum[k][2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
                for (int r = 0; r < 3; r++)
                    win_reg[c][r] <= '0;
        end
        else if (s1_adv)
        begin
            for (int c = 0; c < 3; c++)
                for (int r = 0; r < 3; r++)
                    win_reg[c][r] <= win_next[c][r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_has_reg)
        begin
            for (int k = 0; k < 3; k++)
                s2_sum_reg[k] <= sum_next[k];
            s2_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_adv && s1_has_reg)
            s2_valid_reg <= 1'b1;
        else if (s2_mv)
            s2_valid_reg <= 1'b0;
    end

    // ---------------------------------------------------------------- divide by nine, output
    logic [bbr_pkg::PROD_W-1:0] prod [3];
    logic [CH-1:0]              quot [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod[k] = bbr_pkg::PROD_W'(s2_sum_reg[k]) * bbr_pkg::PROD_W'(bbr_pkg::RECIP9);
            quot[k] = prod[k][bbr_pkg::RECIP9_SHIFT +: CH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_mv)
        begin
            out_color_reg <= {quot[2], quot[1], quot[0], bbr_pkg::ALPHA_OPAQUE};
            out_last_reg  <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_mv)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> tb/sv/box_blur_3x3_rgb_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the 3x3 rgb box blur unit
module box_blur_3x3_rgb_unit_tb;
    import bbr_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int IDLE_PCT      = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int RAND_ITEMS    = 1150;
    localparam int MAX_REPORTS   = 50;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} row_chk_e;

    typedef struct {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       val;
        logic                   cmd;
        logic [IN_W-1:0]        pix;
        row_chk_e               chk;
        logic [IN_W-1:0]        color;
        logic                   last;
    } dir_row_t;

    typedef struct packed {
        logic [IN_W-1:0] color;
        logic            last;
    } blurred_px_t;

    localparam int N_DIR = 24;

    dir_row_t dir_rows [N_DIR] = '{
        // reset size, flush with no frame in progress
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_FLUSH, 32'h0000_0000, CHK_NONE,  32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_FLUSH, 32'hFFFF_FFFF, CHK_NONE,  32'h0, 1'b0},
        // zero registers clamp to a 1x1 frame
        '{ROW_CFG,  REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'h0,         CHK_NONE,  32'h0, 1'b0},
        '{ROW_CFG,  REG_FRAME_HEIGHT, 11'd0,    CMD_PIXEL, 32'h0,         CHK_NONE,  32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'hFFFF_FFFF, CHK_NONE,  32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_FLUSH, 32'h0000_0000, CHK_NONE,  32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_FLUSH, 32'h0000_0000, CHK_VALUE,
          32'h1C1C_1CFF, 1'b1},
        // flush past frame end gives nothing
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_FLUSH, 32'h0000_0000, CHK_NONE,  32'h0, 1'b0},
        '{ROW_CFG,  REG_FRAME_WIDTH,  11'd3,    CMD_PIXEL, 32'h0,         CHK_NONE,  32'h0, 1'b0},
        '{ROW_CFG,  REG_FRAME_HEIGHT, 11'd3,    CMD_PIXEL, 32'h0,         CHK_NONE,  32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'hFF00_0000, CHK_MODEL, 32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'h00FF_0000, CHK_MODEL, 32'h0, 1'b0},
        // flush before the frame is complete is dropped
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_FLUSH, 32'h1234_5678, CHK_NONE,  32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'h0000_FF00, CHK_MODEL, 32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'h0000_00FF, CHK_MODEL, 32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'hFFFF_FFFF, CHK_MODEL, 32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'h0000_0000, CHK_MODEL, 32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'hAAAA_AAAA, CHK_MODEL, 32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'h5555_5555, CHK_MODEL, 32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'h8080_8080, CHK_MODEL, 32'h0, 1'b0},
        // drain, with a pixel standing in for a flush
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_FLUSH, 32'h0000_0000, CHK_MODEL, 32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_PIXEL, 32'hDEAD_BEEF, CHK_MODEL, 32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_FLUSH, 32'h0000_0000, CHK_MODEL, 32'h0, 1'b0},
        '{ROW_ITEM, REG_FRAME_WIDTH,  11'd0,    CMD_FLUSH, 32'h0000_0000, CHK_MODEL, 32'h0, 1'b0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata;   // [31:0] in_pixel
    logic                   s_tuser;   // [0] cmd
    logic                   m_tvalid;
    logic                   m_tready;
    logic [IN_W-1:0]        m_tdata;   // [31:0] out_color
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    // predictor state
    logic [CFG_W-1:0]   frame_w = RESET_WIDTH;
    logic [CFG_W-1:0]   frame_h = RESET_HEIGHT;
    bit [PIX_W-1:0]     above_line [MAX_W];
    bit [PIX_W-1:0]     mid_line [MAX_W];
    bit [PIX_W-1:0]     win [3][3];
    int                 col_pos;
    int                 row_pos;
    int                 out_cnt;

    blurred_px_t        blurred_px_q [$];
    int                 n_fail;
    int                 n_items;
    bit                 no_idle;
    bit                 pressure_go;

    box_blur_3x3_rgb_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_dim(input int v, input int max_v);
        if (v < 1)
            return 1;
        if (v > max_v)
            return max_v;
        return v;
    endfunction

    // advances the window for one request, returns 1 when a blurred pixel comes out
    function automatic bit predict_blur(input logic cmd, input logic [IN_W-1:0] pix,
                                        output logic [IN_W-1:0] color, output logic last);
        int w, h, ci, pos, ox, oy, x, y, k, dc, dr;
        int unsigned rs, gs, bs;
        bit draining;
        bit [PIX_W-1:0] v;
        bit [PIX_W-1:0] p;
        w = clamp_dim(int'(frame_w), MAX_W);
        h = clamp_dim(int'(frame_h), MAX_H);
        draining = (row_pos >= h);
        color = '0;
        last = 1'b0;
        if (cmd == CMD_FLUSH && !draining)
            return 1'b0;
        v = draining ? '0 : pix[IN_W-1:PIX_LO];
        ci = col_pos % MAX_W;
        for (k = 0; k < 3; k++)
        begin
            win[0][k] = win[1][k];
            win[1][k] = win[2][k];
        end
        win[2][0] = above_line[ci];
        win[2][1] = mid_line[ci];
        win[2][2] = v;
        above_line[ci] = mid_line[ci];
        mid_line[ci] = v;
        pos = row_pos * w + col_pos;
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (pos < w + 1)
            return 1'b0;
        ox = out_cnt % w;
        oy = out_cnt / w;
        rs = 0;
        gs = 0;
        bs = 0;
        for (dc = 0; dc < 3; dc++)
        begin
            x = ox + dc - 1;
            for (dr = 0; dr < 3; dr++)
            begin
                y = oy + dr - 1;
                // neighbors outside the frame add nothing, divisor stays nine
                if (x >= 0 && x < w && y >= 0 && y < h)
                begin
                    p = win[dc][dr];
                    rs += p[23:16];
                    gs += p[15:8];
                    bs += p[7:0];
                end
            end
        end
        color = {8'(rs / 9), 8'(gs / 9), 8'(bs / 9), ALPHA_OPAQUE};
        out_cnt++;
        if (out_cnt >= w * h)
        begin
            last = 1'b1;
            out_cnt = 0;
            col_pos = 0;
            row_pos = 0;
        end
        return 1'b1;
    endfunction

    task automatic push_request(input logic cmd, input logic [IN_W-1:0] pix,
                                input row_chk_e chk = CHK_MODEL,
                                input logic [IN_W-1:0] t_color = '0,
                                input logic t_last = 1'b0);
        blurred_px_t px;
        bit got;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        n_items++;
        got = predict_blur(cmd, pix, px.color, px.last);
        if (chk == CHK_VALUE)
        begin
            px.color = t_color;
            px.last  = t_last;
            blurred_px_q.push_back(px);
        end
        else if (chk == CHK_MODEL && got)
            blurred_px_q.push_back(px);
    endtask

    // register writes only once the pipeline has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        while (blurred_px_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            frame_w = val;
        else
            frame_h = val;
    endtask

    task automatic run_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                             input bit write_cfg, input bit hold_rx);
        int w, h, i;
        if (write_cfg)
        begin
            write_reg(REG_FRAME_WIDTH, w_val);
            write_reg(REG_FRAME_HEIGHT, h_val);
        end
        if (hold_rx)
            pressure_go = 1'b1;
        w = clamp_dim(int'(frame_w), MAX_W);
        h = clamp_dim(int'(frame_h), MAX_H);
        for (i = 0; i < w * h; i++)
        begin
            if ($urandom_range(0, 99) < 4)
                push_request(CMD_FLUSH, $urandom);
            push_request(CMD_PIXEL, $urandom);
        end
        for (i = 0; i <= w; i++)
            push_request(($urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_FLUSH, $urandom);
        if ($urandom_range(0, 3) == 0)
            push_request(CMD_FLUSH, $urandom);
    endtask

    // result checker
    always @(posedge clk)
    begin
        blurred_px_t px;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (blurred_px_q.size() == 0)
            begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $error("unexpected result: out_color %h out_last %b", m_tdata, m_tlast);
            end
            else
            begin
                px = blurred_px_q.pop_front();
                if (m_tdata !== px.color)
                begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $error("out_color mismatch: expected %h, actual %h", px.color, m_tdata);
                end
                if (m_tlast !== px.last)
                begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $error("out_last mismatch: expected %b, actual %b", px.last, m_tlast);
                end
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial
    begin : rx_side
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pressure_go && !held)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ends the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
                (m_tvalid === 1'b1 && m_tready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int r, frame_no, small_cnt, start_cnt;
        logic [CFG_W-1:0] w_val, h_val;
        n_fail      = 0;
        n_items     = 0;
        no_idle     = 1'b0;
        pressure_go = 1'b0;
        col_pos     = 0;
        row_pos     = 0;
        out_cnt     = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < N_DIR; r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            else
                push_request(dir_rows[r].cmd, dir_rows[r].pix, dir_rows[r].chk,
                             dir_rows[r].color, dir_rows[r].last);
        end

        frame_no = 0;
        small_cnt = 0;
        while (small_cnt < RAND_ITEMS)
        begin
            if (frame_no == 4)
                // widest line, register above range and zero height
                run_frame(11'd2047, 11'd0, 1'b1, 1'b1);
            else if (frame_no == 9)
            begin
                // tallest frame, streamed without any idle cycles
                no_idle = 1'b1;
                run_frame(11'd0, 11'd2047, 1'b1, 1'b0);
                no_idle = 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       w_val = 11'd0;
                    1, 2:    w_val = CFG_W'($urandom_range(9, 40));
                    default: w_val = CFG_W'($urandom_range(1, 8));
                endcase
                h_val = ($urandom_range(0, 9) == 0) ? 11'd0 : CFG_W'($urandom_range(1, 6));
                start_cnt = n_items;
                run_frame(w_val, h_val, $urandom_range(0, 99) >= 15, 1'b0);
                small_cnt += n_items - start_cnt;
            end
            frame_no++;
        end

        s_tvalid <= 1'b0;
        while (blurred_px_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
